// ===== src/prsl_pkg.sv =====
// Shared types, constants and the sine table generator for the Park rotation block.
package prsl_pkg;

   localparam int TABLE_DEPTH_DEF  = 1024;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int DATA_WIDTH       = 16;
   localparam int ANGLE_WIDTH      = 16;
   localparam int NUM_STAGES       = 5;

   localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 2));

   localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

   typedef enum logic {
      CMD_PARK    = 1'b0,
      CMD_INVERSE = 1'b1
   } command_type;

   // per-stage load enables
   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
      logic en4;
      logic en5;
   } stage_en_type;

   // Q(sample_width-1) sine sample, quarter-wave symmetric, Taylor series in Q30
   function automatic longint sine_sample(input int idx, input int idx_bits,
                                          input int sample_width);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned sn;
      longint unsigned amp;
      longint unsigned mag;
      int qb;
      int quad;
      int r;
      int pos;
      qb   = idx_bits - 2;
      quad = (idx >> qb) & 3;
      r    = idx & ((1 << qb) - 1);
      pos  = quad[0] ? ((1 << qb) - r) : r;
      x    = (Q30_HALF_PI * longint'(pos)) >> qb;
      x2   = (x * x) >> 30;
      t    = Q30_ONE;
      t    = Q30_ONE - (((x2 * t) >> 30) / 156);
      t    = Q30_ONE - (((x2 * t) >> 30) / 110);
      t    = Q30_ONE - (((x2 * t) >> 30) / 72);
      t    = Q30_ONE - (((x2 * t) >> 30) / 42);
      t    = Q30_ONE - (((x2 * t) >> 30) / 20);
      t    = Q30_ONE - (((x2 * t) >> 30) / 6);
      sn   = (x * t) >> 30;
      amp  = (64'd1 << (sample_width - 1)) - 64'd1;
      mag  = (sn * amp + (Q30_ONE >> 1)) >> 30;
      if (mag > amp) begin
         mag = amp;
      end
      return quad[1] ? -longint'(mag) : longint'(mag);
   endfunction

endpackage

// ===== src/prsl_sine_rom.sv =====
// Sine sample ROM with two registered read ports.
module prsl_sine_rom #(
   parameter int TABLE_DEPTH  = prsl_pkg::TABLE_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = prsl_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]    addr_a,
   input  logic [$clog2(TABLE_DEPTH)-1:0]    addr_b,
   output logic signed [SAMPLE_WIDTH-1:0]    data_a,
   output logic signed [SAMPLE_WIDTH-1:0]    data_b
);

   localparam int IdxBits = $clog2(TABLE_DEPTH);

   typedef logic signed [SAMPLE_WIDTH-1:0] rom_type [TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         rom[i] = SAMPLE_WIDTH'(prsl_pkg::sine_sample(i, IdxBits, SAMPLE_WIDTH));
      end
      return rom;
   endfunction

   localparam rom_type RomData = build_rom();

   logic signed [SAMPLE_WIDTH-1:0] data_a_ff;
   logic signed [SAMPLE_WIDTH-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         data_a_ff <= RomData[addr_a];
         data_b_ff <= RomData[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

// ===== src/prsl_interp.sv =====
// Linear interpolation of sine and cosine between adjacent ROM samples.
module prsl_interp #(
   parameter int TABLE_DEPTH  = prsl_pkg::TABLE_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = prsl_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                                     clock,
   input  prsl_pkg::stage_en_type                                   stage_en,
   input  logic [prsl_pkg::ANGLE_WIDTH-$clog2(TABLE_DEPTH)-1:0]     frac,
   input  logic signed [SAMPLE_WIDTH-1:0]                           sin_lo,
   input  logic signed [SAMPLE_WIDTH-1:0]                           sin_hi,
   input  logic signed [SAMPLE_WIDTH-1:0]                           cos_lo,
   input  logic signed [SAMPLE_WIDTH-1:0]                           cos_hi,
   output logic signed [SAMPLE_WIDTH:0]                             sin_val,
   output logic signed [SAMPLE_WIDTH:0]                             cos_val
);

   localparam int FracBits = prsl_pkg::ANGLE_WIDTH - $clog2(TABLE_DEPTH);
   localparam int IntW     = SAMPLE_WIDTH + 1;
   localparam int ProdW    = SAMPLE_WIDTH + FracBits + 2;

   logic [FracBits-1:0]             frac_ff;
   logic signed [IntW-1:0]          sin_diff;
   logic signed [IntW-1:0]          cos_diff;
   logic signed [ProdW-1:0]         frac_ext;
   logic signed [ProdW-1:0]         sin_prod_in;
   logic signed [ProdW-1:0]         cos_prod_in;
   logic signed [ProdW-1:0]         sin_prod_ff;
   logic signed [ProdW-1:0]         cos_prod_ff;
   logic signed [SAMPLE_WIDTH-1:0]  sin_base_ff;
   logic signed [SAMPLE_WIDTH-1:0]  cos_base_ff;
   logic signed [ProdW-1:0]         sin_step;
   logic signed [ProdW-1:0]         cos_step;
   logic signed [IntW-1:0]          sin_in;
   logic signed [IntW-1:0]          cos_in;
   logic signed [IntW-1:0]          sin_ff;
   logic signed [IntW-1:0]          cos_ff;

   // stage 1: fraction travels beside the ROM read
   always_ff @(posedge clock) begin
      if (stage_en.en1) begin
         frac_ff <= frac;
      end
   end

   // stage 2: slope times fraction
   assign sin_diff    = IntW'(sin_hi) - IntW'(sin_lo);
   assign cos_diff    = IntW'(cos_hi) - IntW'(cos_lo);
   assign frac_ext    = ProdW'(signed'({1'b0, frac_ff}));
   assign sin_prod_in = ProdW'(sin_diff) * frac_ext;
   assign cos_prod_in = ProdW'(cos_diff) * frac_ext;

   always_ff @(posedge clock) begin
      if (stage_en.en2) begin
         sin_prod_ff <= sin_prod_in;
         cos_prod_ff <= cos_prod_in;
         sin_base_ff <= sin_lo;
         cos_base_ff <= cos_lo;
      end
   end

   // stage 3: floor shift and add to base sample
   assign sin_step = sin_prod_ff >>> FracBits;
   assign cos_step = cos_prod_ff >>> FracBits;
   assign sin_in   = IntW'(sin_base_ff) + IntW'(sin_step);
   assign cos_in   = IntW'(cos_base_ff) + IntW'(cos_step);

   always_ff @(posedge clock) begin
      if (stage_en.en3) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

// ===== src/prsl_rotate.sv =====
// Rotation products, sum, scaling and saturation.
module prsl_rotate #(
   parameter int SAMPLE_WIDTH = prsl_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                      clock,
   input  prsl_pkg::stage_en_type                    stage_en,
   input  prsl_pkg::command_type                     command,
   input  logic signed [prsl_pkg::DATA_WIDTH-1:0]    first_in,
   input  logic signed [prsl_pkg::DATA_WIDTH-1:0]    second_in,
   input  logic signed [SAMPLE_WIDTH:0]              sin_val,
   input  logic signed [SAMPLE_WIDTH:0]              cos_val,
   output logic signed [prsl_pkg::DATA_WIDTH-1:0]    first_out,
   output logic signed [prsl_pkg::DATA_WIDTH-1:0]    second_out,
   output logic                                      saturated
);

   localparam int DW    = prsl_pkg::DATA_WIDTH;
   localparam int ProdW = SAMPLE_WIDTH + 1 + DW;
   localparam int SumW  = ProdW + 1;
   localparam int Shift = SAMPLE_WIDTH - 1;

   prsl_pkg::command_type     cmd_ff [3:0];
   logic signed [DW-1:0]      a_ff   [2:0];
   logic signed [DW-1:0]      b_ff   [2:0];
   logic signed [ProdW-1:0]   ca_ff;
   logic signed [ProdW-1:0]   sb_ff;
   logic signed [ProdW-1:0]   sa_ff;
   logic signed [ProdW-1:0]   cb_ff;
   logic signed [SumW-1:0]    x_sum;
   logic signed [SumW-1:0]    y_sum;
   logic signed [SumW-1:0]    x_shr;
   logic signed [SumW-1:0]    y_shr;
   logic                      x_clip;
   logic                      y_clip;
   logic signed [DW-1:0]      first_in_v;
   logic signed [DW-1:0]      second_in_v;
   logic signed [DW-1:0]      first_ff;
   logic signed [DW-1:0]      second_ff;
   logic                      sat_ff;

   // stages 1-3: operands wait for sine and cosine
   always_ff @(posedge clock) begin
      if (stage_en.en1) begin
         cmd_ff[0] <= command;
         a_ff[0]   <= first_in;
         b_ff[0]   <= second_in;
      end
      if (stage_en.en2) begin
         cmd_ff[1] <= cmd_ff[0];
         a_ff[1]   <= a_ff[0];
         b_ff[1]   <= b_ff[0];
      end
      if (stage_en.en3) begin
         cmd_ff[2] <= cmd_ff[1];
         a_ff[2]   <= a_ff[1];
         b_ff[2]   <= b_ff[1];
      end
   end

   // stage 4: four products
   always_ff @(posedge clock) begin
      if (stage_en.en4) begin
         cmd_ff[3] <= cmd_ff[2];
         ca_ff     <= ProdW'(cos_val) * ProdW'(a_ff[2]);
         sb_ff     <= ProdW'(sin_val) * ProdW'(b_ff[2]);
         sa_ff     <= ProdW'(sin_val) * ProdW'(a_ff[2]);
         cb_ff     <= ProdW'(cos_val) * ProdW'(b_ff[2]);
      end
   end

   // stage 5: combine, scale, clip
   always_comb begin
      if (cmd_ff[3] == prsl_pkg::CMD_INVERSE) begin
         x_sum = SumW'(ca_ff) - SumW'(sb_ff);
         y_sum = SumW'(sa_ff) + SumW'(cb_ff);
      end else begin
         x_sum = SumW'(ca_ff) + SumW'(sb_ff);
         y_sum = SumW'(cb_ff) - SumW'(sa_ff);
      end
      x_shr  = x_sum >>> Shift;
      y_shr  = y_sum >>> Shift;
      x_clip = !((&x_shr[SumW-1:DW-1]) || !(|x_shr[SumW-1:DW-1]));
      y_clip = !((&y_shr[SumW-1:DW-1]) || !(|y_shr[SumW-1:DW-1]));
      if (x_clip) begin
         first_in_v = x_shr[SumW-1] ? prsl_pkg::DATA_MIN : prsl_pkg::DATA_MAX;
      end else begin
         first_in_v = x_shr[DW-1:0];
      end
      if (y_clip) begin
         second_in_v = y_shr[SumW-1] ? prsl_pkg::DATA_MIN : prsl_pkg::DATA_MAX;
      end else begin
         second_in_v = y_shr[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.en5) begin
         first_ff  <= first_in_v;
         second_ff <= second_in_v;
         sat_ff    <= x_clip || y_clip;
      end
   end

   assign first_out  = first_ff;
   assign second_out = second_ff;
   assign saturated  = sat_ff;

endmodule

// ===== src/park_rotation_sine_lut.sv =====
// Top level: Park / inverse Park rotation with interpolated sine ROM, 5-stage pipeline.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  req_     | in  | first_in[15:0] second_in[31:16] angle[47:32] | command
//  rsp_     | out | first_out[15:0] second_out[31:16]           | saturated
//
//  One beat per cycle sustained while rsp_tready stays high.
//  Stage 1 is the ROM read register; two dual-port ROMs give sine and cosine.
//  Stages: ROM read, slope multiply, interpolate, rotation multiply, sum/clip.
//  Empty stages fill while rsp_ is stalled; a full pipe drops req_tready.
//  Synchronous reset clears the stage valid bits only.
module park_rotation_sine_lut #(
   parameter int TABLE_DEPTH  = prsl_pkg::TABLE_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = prsl_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // first_in, second_in, angle
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // first_out, second_out
   output logic        rsp_tuser    // saturated
);

   localparam int IdxBits  = $clog2(TABLE_DEPTH);
   localparam int FracBits = prsl_pkg::ANGLE_WIDTH - IdxBits;
   localparam int NS       = prsl_pkg::NUM_STAGES;

   logic [NS-1:0]                          valid_ff;
   logic [NS-1:0]                          valid_in;
   logic [NS-1:0]                          ready;
   prsl_pkg::stage_en_type                 stage_en;

   logic signed [prsl_pkg::DATA_WIDTH-1:0] first_in;
   logic signed [prsl_pkg::DATA_WIDTH-1:0] second_in;
   logic [prsl_pkg::ANGLE_WIDTH-1:0]       angle;
   logic [prsl_pkg::ANGLE_WIDTH-1:0]       cos_angle;
   prsl_pkg::command_type                  command;
   logic [IdxBits-1:0]                     sin_idx;
   logic [IdxBits-1:0]                     sin_idx_next;
   logic [IdxBits-1:0]                     cos_idx;
   logic [IdxBits-1:0]                     cos_idx_next;

   logic signed [SAMPLE_WIDTH-1:0]         sin_lo;
   logic signed [SAMPLE_WIDTH-1:0]         sin_hi;
   logic signed [SAMPLE_WIDTH-1:0]         cos_lo;
   logic signed [SAMPLE_WIDTH-1:0]         cos_hi;
   logic signed [SAMPLE_WIDTH:0]           sin_val;
   logic signed [SAMPLE_WIDTH:0]           cos_val;
   logic signed [prsl_pkg::DATA_WIDTH-1:0] first_out;
   logic signed [prsl_pkg::DATA_WIDTH-1:0] second_out;
   logic                                   saturated;

   // bubble-collapsing ready chain
   always_comb begin
      ready[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = req_tvalid;
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign stage_en.en1 = ready[0];
   assign stage_en.en2 = ready[1];
   assign stage_en.en3 = ready[2];
   assign stage_en.en4 = ready[3];
   assign stage_en.en5 = ready[4];

   assign first_in     = req_tdata[15:0];
   assign second_in    = req_tdata[31:16];
   assign angle        = req_tdata[47:32];
   assign command      = prsl_pkg::command_type'(req_tuser);
   assign cos_angle    = angle + prsl_pkg::QUARTER_TURN;
   assign sin_idx      = angle[prsl_pkg::ANGLE_WIDTH-1:FracBits];
   assign cos_idx      = cos_angle[prsl_pkg::ANGLE_WIDTH-1:FracBits];
   assign sin_idx_next = sin_idx + IdxBits'(1);
   assign cos_idx_next = cos_idx + IdxBits'(1);

   prsl_sine_rom #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_sin_rom (
      .clock  (clock),
      .en     (stage_en.en1),
      .addr_a (sin_idx),
      .addr_b (sin_idx_next),
      .data_a (sin_lo),
      .data_b (sin_hi)
   );

   prsl_sine_rom #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_cos_rom (
      .clock  (clock),
      .en     (stage_en.en1),
      .addr_a (cos_idx),
      .addr_b (cos_idx_next),
      .data_a (cos_lo),
      .data_b (cos_hi)
   );

   prsl_interp #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_interp (
      .clock    (clock),
      .stage_en (stage_en),
      .frac     (angle[FracBits-1:0]),
      .sin_lo   (sin_lo),
      .sin_hi   (sin_hi),
      .cos_lo   (cos_lo),
      .cos_hi   (cos_hi),
      .sin_val  (sin_val),
      .cos_val  (cos_val)
   );

   prsl_rotate #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_rotate (
      .clock      (clock),
      .stage_en   (stage_en),
      .command    (command),
      .first_in   (first_in),
      .second_in  (second_in),
      .sin_val    (sin_val),
      .cos_val    (cos_val),
      .first_out  (first_out),
      .second_out (second_out),
      .saturated  (saturated)
   );

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[NS-1];
   assign rsp_tdata  = {second_out, first_out};
   assign rsp_tuser  = saturated;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_tready |-> !req_tready)
      else $error("beat accepted into a full stalled pipeline");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (first_out == prsl_pkg::DATA_MAX) || (first_out == prsl_pkg::DATA_MIN) ||
         (second_out == prsl_pkg::DATA_MAX) || (second_out == prsl_pkg::DATA_MIN))
      else $error("saturation flag without a clipped output");

endmodule

// ===== dv/park_rotation_sine_lut_tb.sv =====
// Self-checking testbench for the Park / inverse Park rotation block.
module park_rotation_sine_lut_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROM_DEPTH    = prsl_pkg::TABLE_DEPTH_DEF;
   localparam int SAMPLE_BITS  = prsl_pkg::SAMPLE_WIDTH_DEF;
   localparam int DATA_BITS    = prsl_pkg::DATA_WIDTH;
   localparam int ANGLE_BITS   = prsl_pkg::ANGLE_WIDTH;
   localparam int FRAC_BITS    = ANGLE_BITS - $clog2(ROM_DEPTH);
   localparam int RANDOM_BEATS = 1200;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PRINT_LIMIT  = 40;

   localparam longint unsigned Q30_UNIT  = 64'd1073741824;
   localparam longint unsigned Q30_RIGHT = 64'd1686629713;

   class rotation_scoreboard;
      typedef struct {
         prsl_pkg::command_type   cmd;
         logic [DATA_BITS-1:0]    first_in;
         logic [DATA_BITS-1:0]    second_in;
         logic [ANGLE_BITS-1:0]   angle;
         logic [DATA_BITS-1:0]    first_out;
         logic [DATA_BITS-1:0]    second_out;
         logic                    saturated;
      } rotation_type;

      longint       sine_rom[ROM_DEPTH];
      rotation_type pending_q[$];
      int           mismatches;

      function new();
         longint unsigned divs[6] = '{156, 110, 72, 42, 20, 6};
         longint unsigned amp;
         longint unsigned x;
         longint unsigned x2;
         longint unsigned t;
         longint unsigned mag;
         longint unsigned pos;
         int q;
         int quad;
         int r;
         mismatches = 0;
         q   = ROM_DEPTH / 4;
         amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
         for (int i = 0; i < ROM_DEPTH; i++) begin
            quad = (i / q) & 3;
            r    = i % q;
            pos  = (quad & 1) ? longint'(q - r) : longint'(r);
            x    = (Q30_RIGHT * pos) / q;
            x2   = (x * x) >> 30;
            t    = Q30_UNIT;
            for (int k = 0; k < 6; k++) begin
               t = Q30_UNIT - (((x2 * t) >> 30) / divs[k]);
            end
            mag = (((x * t) >> 30) * amp + (Q30_UNIT >> 1)) >> 30;
            if (mag > amp) begin
               mag = amp;
            end
            sine_rom[i] = (quad & 2) ? -longint'(mag) : longint'(mag);
         end
      endfunction

      // interpolated sine, floor on the slope term
      function longint sine_at(logic [ANGLE_BITS-1:0] ang);
         int     i0;
         int     i1;
         longint frac;
         i0   = int'(ang >> FRAC_BITS);
         i1   = (i0 + 1) % ROM_DEPTH;
         frac = longint'(ang & ((1 << FRAC_BITS) - 1));
         return sine_rom[i0] + (((sine_rom[i1] - sine_rom[i0]) * frac) >>> FRAC_BITS);
      endfunction

      function longint clip16(longint v, inout logic clipped);
         if (v > 32767) begin
            clipped = 1'b1;
            return 32767;
         end
         if (v < -32768) begin
            clipped = 1'b1;
            return -32768;
         end
         return v;
      endfunction

      function void note_input(prsl_pkg::command_type cmd, logic [DATA_BITS-1:0] a_bits,
                               logic [DATA_BITS-1:0] b_bits, logic [ANGLE_BITS-1:0] ang);
         rotation_type          item;
         longint                s;
         longint                c;
         longint                a;
         longint                b;
         longint                x;
         longint                y;
         logic [ANGLE_BITS-1:0] cos_ang;
         logic                  clipped;
         cos_ang = ang + prsl_pkg::QUARTER_TURN;
         s       = sine_at(ang);
         c       = sine_at(cos_ang);
         a       = longint'($signed(a_bits));
         b       = longint'($signed(b_bits));
         clipped = 1'b0;
         if (cmd == prsl_pkg::CMD_PARK) begin
            x = c * a + s * b;
            y = c * b - s * a;
         end else begin
            x = c * a - s * b;
            y = s * a + c * b;
         end
         x = clip16(x >>> (SAMPLE_BITS - 1), clipped);
         y = clip16(y >>> (SAMPLE_BITS - 1), clipped);
         item.cmd        = cmd;
         item.first_in   = a_bits;
         item.second_in  = b_bits;
         item.angle      = ang;
         item.first_out  = x[DATA_BITS-1:0];
         item.second_out = y[DATA_BITS-1:0];
         item.saturated  = clipped;
         pending_q.push_back(item);
      endfunction

      task report_mismatch(string msg);
         if (mismatches < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
         mismatches++;
      endtask

      task check_result(logic [31:0] data, logic sat);
         rotation_type exp_item;
         string        tag;
         if (pending_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat data=%h sat=%b", data, sat));
         end else begin
            exp_item = pending_q.pop_front();
            tag = $sformatf("%s a=%h b=%h angle=%h", exp_item.cmd.name(),
                            exp_item.first_in, exp_item.second_in, exp_item.angle);
            if (data[15:0] !== exp_item.first_out) begin
               report_mismatch($sformatf("%s first_out got %h exp %h", tag,
                                         data[15:0], exp_item.first_out));
            end
            if (data[31:16] !== exp_item.second_out) begin
               report_mismatch($sformatf("%s second_out got %h exp %h", tag,
                                         data[31:16], exp_item.second_out));
            end
            if (sat !== exp_item.saturated) begin
               report_mismatch($sformatf("%s saturated got %b exp %b", tag,
                                         sat, exp_item.saturated));
            end
         end
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;    // first_in, second_in, angle
   logic        req_tuser  = 1'b0;  // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // first_out, second_out
   logic        rsp_tuser;          // saturated

   int  cycle_count  = 0;
   bit  no_gaps      = 1'b0;
   bit  hold_request = 1'b0;

   rotation_scoreboard rot_sb = new();

   park_rotation_sine_lut u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("park_rotation_sine_lut_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            rot_sb.note_input(prsl_pkg::command_type'(req_tuser), req_tdata[15:0],
                              req_tdata[31:16], req_tdata[47:32]);
         end
         if (rsp_tvalid && rsp_tready) begin
            rot_sb.check_result(rsp_tdata, rsp_tuser);
         end
      end
   end

   // mostly short gaps, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DATA_BITS-1:0] pick_sample();
      logic [DATA_BITS-1:0] corners[4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
      if ($urandom_range(0, 99) < 85) begin
         return DATA_BITS'($urandom);
      end
      return corners[$urandom_range(0, 3)];
   endfunction

   // uniform, or close to a quadrant boundary
   function automatic logic [ANGLE_BITS-1:0] pick_angle();
      if ($urandom_range(0, 99) < 80) begin
         return ANGLE_BITS'($urandom);
      end
      return ANGLE_BITS'(($urandom_range(0, 3) << 14) + $urandom_range(0, 127) - 64);
   endfunction

   task automatic send_rotation(prsl_pkg::command_type cmd, logic [DATA_BITS-1:0] a,
                                logic [DATA_BITS-1:0] b, logic [ANGLE_BITS-1:0] ang);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {ang, b, a};
      do @(posedge clock); while (!req_tready);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         stall = pick_gap();
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // axes, extremes, 45 degree saturation, last-entry wrap, interpolation edges
      send_rotation(prsl_pkg::CMD_PARK,    16'h7FFF, 16'h0000, 16'h0000);
      send_rotation(prsl_pkg::CMD_PARK,    16'h0000, 16'h7FFF, 16'h4000);
      send_rotation(prsl_pkg::CMD_INVERSE, 16'h8000, 16'h7FFF, 16'h8000);
      send_rotation(prsl_pkg::CMD_INVERSE, 16'h7FFF, 16'h8000, 16'hC000);
      send_rotation(prsl_pkg::CMD_PARK,    16'h8000, 16'h8000, 16'h2000);
      send_rotation(prsl_pkg::CMD_INVERSE, 16'h7FFF, 16'h7FFF, 16'h2000);
      send_rotation(prsl_pkg::CMD_PARK,    16'h7FFF, 16'h8000, 16'hE000);
      send_rotation(prsl_pkg::CMD_INVERSE, 16'h8000, 16'h8000, 16'h6000);
      send_rotation(prsl_pkg::CMD_PARK,    16'h8000, 16'h7FFF, 16'hA000);
      send_rotation(prsl_pkg::CMD_INVERSE, 16'h7FFF, 16'h8000, 16'h6000);
      send_rotation(prsl_pkg::CMD_PARK,    16'h1234, 16'hEDCB, 16'hFFFF);
      send_rotation(prsl_pkg::CMD_INVERSE, 16'hFFFF, 16'h0001, 16'hFFC0);
      send_rotation(prsl_pkg::CMD_PARK,    16'h8000, 16'h0000, 16'h003F);
      send_rotation(prsl_pkg::CMD_INVERSE, 16'h0000, 16'h8000, 16'h0040);
      send_rotation(prsl_pkg::CMD_PARK,    16'h0000, 16'h0000, 16'h5555);
      send_rotation(prsl_pkg::CMD_INVERSE, 16'hFFFF, 16'hFFFF, 16'hAAAA);
      send_rotation(prsl_pkg::CMD_PARK,    16'h7FFF, 16'h7FFF, 16'h3FFF);
      send_rotation(prsl_pkg::CMD_INVERSE, 16'h8000, 16'h7FFF, 16'hBFC1);
      send_rotation(prsl_pkg::CMD_PARK,    16'h8000, 16'h8000, 16'h8000);
      send_rotation(prsl_pkg::CMD_INVERSE, 16'h8000, 16'h8000, 16'h0000);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == 200) begin
            hold_request = 1'b1;
         end
         no_gaps = (n >= 500 && n < 650);
         send_rotation(prsl_pkg::command_type'($urandom_range(0, 1)), pick_sample(),
                       pick_sample(), pick_angle());
      end
      req_tvalid <= 1'b0;

      while (rot_sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rot_sb.mismatches == 0) begin
         $display("park_rotation_sine_lut_tb: PASS");
      end else begin
         $display("park_rotation_sine_lut_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/prsl_pkg.sv
src/prsl_sine_rom.sv
src/prsl_interp.sv
src/prsl_rotate.sv
src/park_rotation_sine_lut.sv
dv/park_rotation_sine_lut_tb.sv
